### rtl/period_frequency_band_detector_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the period frequency band detector RTL
// Each macro checks a property on the rising edge of clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef PERIOD_FREQUENCY_BAND_DETECTOR_ASSERT_SVH
`define PERIOD_FREQUENCY_BAND_DETECTOR_ASSERT_SVH

// Same-cycle implication: cond holds, so prop holds in this cycle
`define PFBD_ASSERT_IMP(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("pfbd assertion failed");

// Next-cycle implication: cond holds, so prop holds in the following cycle
`define PFBD_ASSERT_NXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("pfbd assertion failed");

`endif

### rtl/pfbd_pkg.sv
// ----------------------------------------------------------------------------
// pfbd_pkg
// Types, constants and helper functions of the period frequency band detector.
// ----------------------------------------------------------------------------
package pfbd_pkg;

    // Ring of recent periods
    localparam int RING_DEPTH = 3;
    localparam int IDX_W      = $clog2(RING_DEPTH);
    localparam int SLOT_W     = $clog2(RING_DEPTH + 1);

    // Datapath widths
    localparam int DATA_W     = 16;
    localparam int BAND_W     = 3;
    localparam int CNT_W      = $clog2(DATA_W);

    // Stream words
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 24;

    // Configuration port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic [APB_AW-3:0] REG_CLOCK_RATIO = '0;

    // Input word kinds carried on tuser
    localparam logic ACT_CAPTURE = 1'b0;
    localparam logic ACT_POLL    = 1'b1;

    // Reset values
    localparam logic [DATA_W-1:0] RATIO_RESET  = 16'd14746;
    localparam logic [DATA_W-1:0] PERIOD_RESET = 16'd270;
    localparam logic [BAND_W-1:0] BAND_RESET   = 3'd3;

    // Agreement window between neighboring periods
    localparam logic [DATA_W-1:0] TOLERANCE = 16'd2;
    localparam logic [DATA_W-1:0] FREQ_MAX  = 16'hFFFF;

    // Band thresholds
    localparam logic [DATA_W-1:0] THR_LOW = 16'd1000;
    localparam logic [DATA_W-1:0] THR_B1  = 16'd2500;
    localparam logic [DATA_W-1:0] THR_B2  = 16'd5000;
    localparam logic [DATA_W-1:0] THR_B3  = 16'd12000;
    localparam logic [DATA_W-1:0] THR_B4  = 16'd20000;
    localparam logic [DATA_W-1:0] THR_B5  = 16'd23000;

    localparam logic [BAND_W-1:0] BAND_0 = 3'd0;
    localparam logic [BAND_W-1:0] BAND_1 = 3'd1;
    localparam logic [BAND_W-1:0] BAND_2 = 3'd2;
    localparam logic [BAND_W-1:0] BAND_3 = 3'd3;
    localparam logic [BAND_W-1:0] BAND_4 = 3'd4;
    localparam logic [BAND_W-1:0] BAND_5 = 3'd5;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_RESULT
    } state_t;

    // Status of the serial divider
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // Map a frequency to its band, keep the held band below the lowest threshold
    function automatic logic [BAND_W-1:0] pick_band(input logic [DATA_W-1:0] freq,
                                                    input logic [BAND_W-1:0] held);
        logic [BAND_W-1:0] band;
        if (freq < THR_LOW)
            band = held;
        else if (freq < THR_B1)
            band = BAND_0;
        else if (freq < THR_B2)
            band = BAND_1;
        else if (freq < THR_B3)
            band = BAND_2;
        else if (freq < THR_B4)
            band = BAND_3;
        else if (freq < THR_B5)
            band = BAND_4;
        else
            band = BAND_5;
        return band;
    endfunction

endpackage

### rtl/period_frequency_band_detector.sv
// Capture word: accepted in the idle state, which it does not leave, so ready again in the next cycle.
// Poll word: divider steps, then the scaled quotient is registered as the frequency,
// then the output load; an unstable poll skips the divider and goes to the load.
// The next word is accepted the cycle after the result enters the output register.
// Reset (rst_n, asynchronous, active low) loads the period ring with 270,
// clock_ratio with 14746, the held band with 3, and empties the output register.
// ----------------------------------------------------------------------------
// period_frequency_band_detector
// Reciprocal frequency counter: stores timer periods in a ring, divides the
// clock ratio by the slot-0 period on a poll whose periods agree, and selects a band.
// ----------------------------------------------------------------------------
`include "period_frequency_band_detector_assert.svh"

module period_frequency_band_detector
    import pfbd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Input stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [15:0] capture_time
    input  logic                   s_axis_tuser,   // [0] action
    // Result stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [15:0] frequency, [16] stable,
                                                   // [19:17] band, [23:20] zero
    // Configuration port
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_AW-1:0]      paddr,
    input  logic [APB_DW-1:0]      pwdata,
    output logic [APB_DW-1:0]      prdata,
    output logic                   pready
);

    state_t state_reg, state_next;

    logic [DATA_W-1:0] ring_reg [RING_DEPTH];
    logic [DATA_W-1:0] ring_next [RING_DEPTH];
    logic [SLOT_W-1:0] write_slot_reg, write_slot_next;
    logic [DATA_W-1:0] last_stamp_reg, last_stamp_next;
    logic [BAND_W-1:0] band_held_reg, band_held_next;
    logic [DATA_W-1:0] ratio_reg, ratio_next;
    logic [DATA_W-1:0] freq_reg, freq_next;
    logic              stable_reg, stable_next;
    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] out_freq_reg, out_freq_next;
    logic              out_stable_reg, out_stable_next;
    logic [BAND_W-1:0] out_band_reg, out_band_next;

    logic                  in_accept;
    logic                  capture_accept;
    logic                  poll_accept;
    logic                  go_div;
    logic                  div_start;
    logic                  out_load;
    logic                  cfg_write;
    logic                  cfg_hit;
    logic [RING_DEPTH-2:0] pair_ok;
    logic                  agree;
    logic [IDX_W-1:0]      write_idx;
    logic [DATA_W-1:0]     period;
    logic [DATA_W-1:0]     scaled;
    logic [BAND_W-1:0]     band_new;
    div_stat_t             div_stat;
    logic [DATA_W-1:0]     quotient;

    // Serial divider, started by a poll whose periods agree and whose slot-0 period is nonzero
    pfbd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (ratio_reg),
        .divisor  (ring_reg[0]),
        .stat     (div_stat),
        .quotient (quotient)
    );

    // Handshake terms
    assign in_accept      = s_axis_tvalid && s_axis_tready;
    assign capture_accept = in_accept && (s_axis_tuser == ACT_CAPTURE);
    assign poll_accept    = in_accept && (s_axis_tuser == ACT_POLL);

    // Check each neighboring pair of periods against the window
    always_comb
    begin
        for (int i = 0; i < RING_DEPTH - 1; i++)
        begin
            if (ring_reg[i] > ring_reg[i+1])
                pair_ok[i] = (ring_reg[i] - ring_reg[i+1]) <= TOLERANCE;
            else
                pair_ok[i] = (ring_reg[i+1] - ring_reg[i]) <= TOLERANCE;
        end
    end

    assign agree  = &pair_ok;
    assign go_div = agree && (ring_reg[0] != '0);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (poll_accept)
                    state_next = go_div ? ST_DIV : ST_RESULT;
            end
            ST_DIV:
            begin
                if (div_stat.done)
                    state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (!out_valid_reg || m_axis_tready)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        s_axis_tready = 1'b0;
        div_start     = 1'b0;
        out_load      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                div_start     = poll_accept && go_div;
            end
            ST_DIV:
            begin
                s_axis_tready = 1'b0;
            end
            ST_RESULT:
            begin
                out_load = !out_valid_reg || m_axis_tready;
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // Ring write position: wrap to slot 0 once the ring is full
    always_comb
    begin
        if (write_slot_reg >= SLOT_W'(RING_DEPTH))
        begin
            write_idx       = '0;
            write_slot_next = SLOT_W'(1);
        end
        else
        begin
            write_idx       = write_slot_reg[IDX_W-1:0];
            write_slot_next = write_slot_reg + 1'b1;
        end
    end

    assign period = s_axis_tdata[DATA_W-1:0] - last_stamp_reg;

    // Store the period of a capture word
    always_comb
    begin
        for (int i = 0; i < RING_DEPTH; i++)
            ring_next[i] = ring_reg[i];
        last_stamp_next = last_stamp_reg;
        if (capture_accept)
        begin
            ring_next[write_idx] = period;
            last_stamp_next      = s_axis_tdata[DATA_W-1:0];
        end
    end

    // Scale the quotient by 256 and saturate
    assign scaled = (quotient[DATA_W-1:8] != '0) ? FREQ_MAX : {quotient[7:0], 8'h00};

    // Hold the measured frequency until the result is built
    always_comb
    begin
        freq_next   = freq_reg;
        stable_next = stable_reg;
        if (poll_accept && !go_div)
        begin
            freq_next   = '0;
            stable_next = 1'b0;
        end
        else if (state_reg == ST_DIV && div_stat.done)
        begin
            freq_next   = scaled;
            stable_next = 1'b1;
        end
    end

    assign band_new = pick_band(freq_reg, band_held_reg);

    // Load the output register and update the held band
    always_comb
    begin
        band_held_next  = band_held_reg;
        out_valid_next  = out_valid_reg;
        out_freq_next   = out_freq_reg;
        out_stable_next = out_stable_reg;
        out_band_next   = out_band_reg;
        if (m_axis_tready)
            out_valid_next = 1'b0;
        if (out_load)
        begin
            band_held_next  = band_new;
            out_valid_next  = 1'b1;
            out_freq_next   = freq_reg;
            out_stable_next = stable_reg;
            out_band_next   = band_new;
        end
    end

    // Configuration write and read
    assign cfg_hit    = (paddr[APB_AW-1:2] == REG_CLOCK_RATIO);
    assign cfg_write  = psel && penable && pwrite && pready && cfg_hit;
    assign ratio_next = cfg_write ? pwdata[DATA_W-1:0] : ratio_reg;
    assign pready     = 1'b1;
    assign prdata     = cfg_hit ? {{(APB_DW-DATA_W){1'b0}}, ratio_reg} : '0;

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            for (int i = 0; i < RING_DEPTH; i++)
                ring_reg[i] <= PERIOD_RESET;
            write_slot_reg <= '0;
            last_stamp_reg <= '0;
            band_held_reg  <= BAND_RESET;
            ratio_reg      <= RATIO_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            for (int i = 0; i < RING_DEPTH; i++)
                ring_reg[i] <= ring_next[i];
            if (capture_accept)
                write_slot_reg <= write_slot_next;
            last_stamp_reg <= last_stamp_next;
            band_held_reg  <= band_held_next;
            ratio_reg      <= ratio_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        freq_reg       <= freq_next;
        stable_reg     <= stable_next;
        out_freq_reg   <= out_freq_next;
        out_stable_reg <= out_stable_next;
        out_band_reg   <= out_band_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W-DATA_W-1-BAND_W){1'b0}},
                            out_band_reg, out_stable_reg, out_freq_reg};

    // Checks
    `PFBD_ASSERT_IMP(a_done_in_div, div_stat.done, state_reg == ST_DIV)
    `PFBD_ASSERT_NXT(a_unstable_skips_div, poll_accept && !go_div,
                     state_reg == ST_RESULT && !stable_reg && freq_reg == '0)
    `PFBD_ASSERT_IMP(a_slot_in_range, 1'b1, write_slot_reg <= SLOT_W'(RING_DEPTH))
    `PFBD_ASSERT_IMP(a_band_in_range, out_valid_reg, out_band_reg <= BAND_5)

endmodule

### rtl/pfbd_div.sv
// ----------------------------------------------------------------------------
// pfbd_div
// Restoring serial divider: one quotient bit per cycle while busy.
// ----------------------------------------------------------------------------
`include "period_frequency_band_detector_assert.svh"

module pfbd_div
    import pfbd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DATA_W-1:0] dividend,
    input  logic [DATA_W-1:0] divisor,
    output div_stat_t         stat,
    output logic [DATA_W-1:0] quotient
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DATA_W:0]   rem_reg, rem_next;
    logic [DATA_W-1:0] quo_reg, quo_next;
    logic [DATA_W-1:0] dsr_reg, dsr_next;

    logic [DATA_W:0]   rem_shift;
    logic [DATA_W+1:0] diff;
    logic              last_step;

    // Shared subtractor: trial subtract of the divisor from the shifted remainder
    assign rem_shift = {rem_reg[DATA_W-1:0], quo_reg[DATA_W-1]};
    assign diff      = {1'b0, rem_shift} - {2'b00, dsr_reg};
    assign last_step = (cnt_reg == CNT_W'(DATA_W - 1));

    // Advance one quotient bit per busy cycle
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (diff[DATA_W+1])
            begin
                rem_next = rem_shift;
                quo_next = {quo_reg[DATA_W-2:0], 1'b0};
            end
            else
            begin
                rem_next = diff[DATA_W:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b1};
            end
            cnt_next = cnt_reg + 1'b1;
            if (last_step)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

    // Checks
    `PFBD_ASSERT_IMP(a_div_start_idle, start, !busy_reg)
    `PFBD_ASSERT_NXT(a_div_done_after_last, busy_reg && last_step, done_reg && !busy_reg)
    `PFBD_ASSERT_IMP(a_div_done_not_busy, done_reg, !busy_reg)

endmodule
